### rtl/ssit_pkg.sv
// Shared definitions for the sparse-set index table: default sizes,
// operation and status codes, and the sequencer state type.
// Depends on nothing; used by every module under rtl/.
package ssit_pkg;

  localparam int DEF_MAX_ENTITIES = 1024;
  localparam int DEF_CAPACITY     = 64;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [2:0] STAT_INSERTED = 3'd0;
  localparam logic [2:0] STAT_PRESENT  = 3'd1;
  localparam logic [2:0] STAT_REMOVED  = 3'd2;
  localparam logic [2:0] STAT_ABSENT   = 3'd3;
  localparam logic [2:0] STAT_FULL     = 3'd4;

  typedef enum logic [1:0] {
    SEQ_CLEAR,
    SEQ_IDLE,
    SEQ_EXEC,
    SEQ_FIXUP
  } seq_state_t;

endpackage

### rtl/ssit_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Depends on ssit_pkg for default sizes.
module ssit_ram #(
  parameter int WIDTH = ssit_pkg::DEF_CAPACITY,
  parameter int DEPTH = ssit_pkg::DEF_CAPACITY,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/sparse_set_index_table_core.sv
// Sparse-set index table top level: sequencer around two RAMs.
// Depends on ssit_pkg and ssit_ram.
//
// Maps entity ids to slots of a packed array. Each command word (opcode,
// entity_id) is taken at a rising edge with start high and busy low. Its
// single result word is registered at the end of EXEC and appears on status,
// slot_index, moved, moved_entity and entry_total, qualified by done for
// exactly one cycle; the receiver cannot stall, so sample the result word
// while done is high. Insert, lookup and a plain remove go from EXEC back
// to IDLE; a remove that moves another entity into the freed slot passes
// through FIXUP first, as the single-port entity map RAM needs a second
// write to repoint the moved entity. The synchronous RAM reads (entity map
// at the id, packed array at the last slot) are issued together in IDLE;
// decision and write-back follow in EXEC. After reset, busy stays high
// while the entity map is swept to empty, one entry per cycle.
module sparse_set_index_table_core #(
  parameter int MAX_ENTITIES = ssit_pkg::DEF_MAX_ENTITIES,
  parameter int CAPACITY     = ssit_pkg::DEF_CAPACITY,
  localparam int ID_W   = $clog2(MAX_ENTITIES),
  localparam int SLOT_W = $clog2(CAPACITY),
  localparam int CNT_W  = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        opcode,
  input  logic [ID_W-1:0]   entity_id,
  output logic              done,
  output logic [2:0]        status,
  output logic [SLOT_W-1:0] slot_index,
  output logic              moved,
  output logic [ID_W-1:0]   moved_entity,
  output logic [CNT_W-1:0]  entry_total
);

  localparam int MAP_W = SLOT_W + 1;  // valid bit over slot

  ssit_pkg::seq_state_t state, state_next;

  // Command word latched at accept
  logic [1:0]        op_q;
  logic [ID_W-1:0]   id_q;
  logic              in_range_q;

  logic [CNT_W-1:0]  count, count_next;
  logic [ID_W-1:0]   clr_addr;

  // Pending repoint of the moved entity
  logic [ID_W-1:0]   fix_id;
  logic [SLOT_W-1:0] fix_slot;

  // RAM ports
  logic              map_we;
  logic [ID_W-1:0]   map_addr;
  logic [MAP_W-1:0]  map_wdata, map_rdata;
  logic              slot_we;
  logic [SLOT_W-1:0] slot_addr;
  logic [ID_W-1:0]   slot_wdata, slot_rdata;

  // Decision in EXEC
  logic              hit;
  logic [SLOT_W-1:0] hit_slot;
  logic [SLOT_W-1:0] last_slot;
  logic              do_insert, do_remove, do_move;
  logic [2:0]        res_status;
  logic [SLOT_W-1:0] res_slot;

  assign hit       = map_rdata[SLOT_W];
  assign hit_slot  = map_rdata[SLOT_W-1:0];
  assign last_slot = SLOT_W'(count - 1'b1);

  ssit_ram #(.WIDTH(MAP_W), .DEPTH(MAX_ENTITIES)) u_map (
    .clk   (clk),
    .we    (map_we),
    .addr  (map_addr),
    .wdata (map_wdata),
    .rdata (map_rdata)
  );

  ssit_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_slots (
    .clk   (clk),
    .we    (slot_we),
    .addr  (slot_addr),
    .wdata (slot_wdata),
    .rdata (slot_rdata)
  );

  // Decide the outcome of the latched command from the RAM read data.
  always_comb begin
    do_insert  = 1'b0;
    do_remove  = 1'b0;
    do_move    = 1'b0;
    res_status = ssit_pkg::STAT_ABSENT;
    res_slot   = '0;
    count_next = count;
    if (in_range_q) begin
      case (op_q)
        ssit_pkg::OP_INSERT: begin
          if (hit) begin
            res_status = ssit_pkg::STAT_PRESENT;
            res_slot   = hit_slot;
          end else if (count == CNT_W'(CAPACITY)) begin
            res_status = ssit_pkg::STAT_FULL;
          end else begin
            do_insert  = 1'b1;
            res_status = ssit_pkg::STAT_INSERTED;
            res_slot   = SLOT_W'(count);
            count_next = count + 1'b1;
          end
        end
        ssit_pkg::OP_REMOVE: begin
          if (hit && (count != '0)) begin
            do_remove  = 1'b1;
            do_move    = (hit_slot != last_slot);
            res_status = ssit_pkg::STAT_REMOVED;
            res_slot   = hit_slot;
            count_next = count - 1'b1;
          end
        end
        default: begin
          // lookup, and the unused opcode acts as one
          if (hit) begin
            res_status = ssit_pkg::STAT_PRESENT;
            res_slot   = hit_slot;
          end
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ssit_pkg::SEQ_CLEAR: begin
        if (clr_addr == ID_W'(MAX_ENTITIES - 1)) state_next = ssit_pkg::SEQ_IDLE;
      end
      ssit_pkg::SEQ_IDLE: begin
        if (start) state_next = ssit_pkg::SEQ_EXEC;
      end
      ssit_pkg::SEQ_EXEC: begin
        state_next = do_move ? ssit_pkg::SEQ_FIXUP : ssit_pkg::SEQ_IDLE;
      end
      ssit_pkg::SEQ_FIXUP: begin
        state_next = ssit_pkg::SEQ_IDLE;
      end
      default: state_next = ssit_pkg::SEQ_CLEAR;
    endcase
  end

  // RAM controls per state
  always_comb begin
    busy       = 1'b1;
    map_we     = 1'b0;
    map_addr   = entity_id;
    map_wdata  = '0;
    slot_we    = 1'b0;
    slot_addr  = last_slot;
    slot_wdata = id_q;
    case (state)
      ssit_pkg::SEQ_CLEAR: begin
        // sweep the map to empty
        map_we   = 1'b1;
        map_addr = clr_addr;
      end
      ssit_pkg::SEQ_IDLE: begin
        // read the map at the id and the packed array at the last slot
        busy = 1'b0;
      end
      ssit_pkg::SEQ_EXEC: begin
        map_addr = id_q;
        if (do_insert) begin
          map_we     = 1'b1;
          map_wdata  = {1'b1, SLOT_W'(count)};
          slot_we    = 1'b1;
          slot_addr  = SLOT_W'(count);
          slot_wdata = id_q;
        end else if (do_remove) begin
          // drop the removed id, move the last entity into the freed slot
          map_we     = 1'b1;
          map_wdata  = '0;
          slot_we    = 1'b1;
          slot_addr  = hit_slot;
          slot_wdata = slot_rdata;
        end
      end
      ssit_pkg::SEQ_FIXUP: begin
        // repoint the moved entity at its new slot
        map_we    = 1'b1;
        map_addr  = fix_id;
        map_wdata = {1'b1, fix_slot};
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ssit_pkg::SEQ_CLEAR;
      clr_addr <= '0;
      count    <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ssit_pkg::SEQ_EXEC);
      if (state == ssit_pkg::SEQ_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == ssit_pkg::SEQ_EXEC) begin
        count <= count_next;
      end
    end
  end

  // Payload registers: command latch, repoint target, result word
  always_ff @(posedge clk) begin
    if (state == ssit_pkg::SEQ_IDLE && start) begin
      op_q       <= opcode;
      id_q       <= entity_id;
      in_range_q <= ({1'b0, entity_id} < (ID_W + 1)'(MAX_ENTITIES));
    end
    if (state == ssit_pkg::SEQ_EXEC) begin
      fix_id       <= slot_rdata;
      fix_slot     <= hit_slot;
      status       <= res_status;
      slot_index   <= res_slot;
      moved        <= do_move;
      moved_entity <= do_move ? slot_rdata : '0;
      entry_total  <= count_next;
    end
  end

endmodule
